FILE: src/sqird_pkg.sv
package sqird_pkg;

  // Request codes.
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_DELETE = 1'b1;

  // Configuration register byte address, one 32-bit word per register.
  localparam logic [2:0] ADDR_ACTIVE = 3'd0;
  localparam logic [3:0] ACTIVE_RESET = 4'd8;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_DELETED  = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOD,
    S_SCAN,
    S_ACT,
    S_RDWAIT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic       req_type;
    logic [7:0] data_in;
  } req_t;

  typedef struct packed {
    status_t    status;
    logic [2:0] queue_index;
    logic [7:0] data_out;
    logic [6:0] queue_level;
  } rsp_t;

endpackage

FILE: src/shortest_queue_insert_rr_delete.sv
// Join-shortest-queue byte buffer with round-robin removal.
// Requests arrive on the req channel (req_valid, req_stall, req); each request
// transaction is either an insert of one byte or a delete. Every request makes
// exactly one result transaction on the rsp channel (rsp_valid, rsp_stall, rsp).
// An insert puts its byte at the tail of the shortest active queue, ties going
// to the lowest index, or reports that all queues are full. A delete scans from
// the round-robin pointer for the first non-empty queue and pops its head byte,
// or reports that all queues are empty; the pointer moves on after every delete.
// The number of active queues is set through the APB register at address 0.
// One request is handled at a time. A single count read port and comparator
// visit one queue per cycle. An insert scans every active queue and then
// writes its byte. A delete first reduces the pointer modulo the active
// queue count, by repeated subtraction when the count was lowered, then scans
// up to the first non-empty queue and reads its head byte from the RAM. The
// result register lets the next request be accepted while an earlier result
// is still stalled; the block then waits in its final step until the result
// register is free.
// Synchronous reset empties all queues, clears the pointer and sets the active
// count to eight.
module shortest_queue_insert_rr_delete #(
  parameter int QUEUES = 8,
  parameter int DEPTH  = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  sqird_pkg::req_t   req,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output sqird_pkg::rsp_t   rsp,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  import sqird_pkg::*;

  localparam int QW = (QUEUES > 1) ? $clog2(QUEUES) : 1;
  localparam int HW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = QW + HW;
  localparam int SW = (QW > 4) ? QW : 4;

  // Configuration register.
  logic [3:0] active_q;
  logic [3:0] n_eff;

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_ACTIVE) ? {28'd0, active_q} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_q <= ACTIVE_RESET;
    end else if (psel && penable && pwrite && (paddr == ADDR_ACTIVE)) begin
      active_q <= pwdata[3:0];
    end
  end

  // A count of zero acts as one and a count above QUEUES acts as QUEUES.
  always_comb begin
    if (active_q == 4'd0) begin
      n_eff = 4'd1;
    end else if (int'(active_q) > QUEUES) begin
      n_eff = 4'(QUEUES);
    end else begin
      n_eff = active_q;
    end
  end

  // Queue bookkeeping.
  logic [CW-1:0] cnt  [QUEUES];
  logic [HW-1:0] head [QUEUES];
  logic [QW-1:0] rr_ptr;

  // Sequencer state and working registers.
  state_t        state;
  state_t        state_next;
  req_t          cur;
  logic [QW-1:0] scan_q;
  logic [QW-1:0] best;
  logic [CW-1:0] best_cnt;
  logic [3:0]    step;
  logic          found;
  rsp_t          res;

  logic          accept;
  logic          out_free;
  logic [QW-1:0] rd_q;
  logic [CW-1:0] rd_cnt;
  logic [HW-1:0] rd_head;
  logic          scan_last;
  logic          mod_more;
  logic [QW-1:0] scan_wrap;
  logic          is_full;
  logic [CW:0]   tail_sum;
  logic [HW-1:0] tail;
  logic [HW-1:0] head_inc;

  logic          ram_we;
  logic          ram_re;
  logic [AW-1:0] ram_waddr;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  assign accept   = req_valid && !req_stall;
  assign req_stall = (state != S_IDLE);
  assign out_free = !rsp_valid || !rsp_stall;

  // The single count read port serves the scan, then the chosen queue.
  assign rd_q    = (state == S_SCAN) ? scan_q : best;
  assign rd_cnt  = cnt[rd_q];
  assign rd_head = head[best];

  assign scan_last = (step == (n_eff - 4'd1));
  assign mod_more  = (SW'(scan_q) >= SW'(n_eff));
  assign scan_wrap = (SW'(scan_q) == (SW'(n_eff) - SW'(1))) ? '0 : scan_q + QW'(1);

  assign is_full  = (best_cnt == CW'(DEPTH));
  assign tail_sum = (CW + 1)'(rd_head) + (CW + 1)'(best_cnt);
  assign tail     = (tail_sum >= (CW + 1)'(DEPTH)) ? HW'(tail_sum - (CW + 1)'(DEPTH))
                                                    : HW'(tail_sum);
  assign head_inc = (rd_head == HW'(DEPTH - 1)) ? '0 : rd_head + HW'(1);

  assign ram_we    = (state == S_ACT) && (cur.req_type == REQ_INSERT) && !is_full;
  assign ram_waddr = {best, tail};
  assign ram_re    = (state == S_ACT) && (cur.req_type == REQ_DELETE) && found;
  assign ram_raddr = {best, rd_head};

  sqird_ram #(
    .AW(AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (cur.data_in),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = (req.req_type == REQ_DELETE) ? S_MOD : S_SCAN;
        end
      end
      S_MOD: begin
        if (!mod_more) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_last || ((cur.req_type == REQ_DELETE) && (rd_cnt != '0))) begin
          state_next = S_ACT;
        end
      end
      S_ACT: begin
        state_next = ram_re ? S_RDWAIT : S_DONE;
      end
      S_RDWAIT: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Working registers of the sequencer.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          cur    <= req;
          step   <= '0;
          found  <= 1'b0;
          scan_q <= (req.req_type == REQ_DELETE) ? rr_ptr : '0;
        end
      end
      S_MOD: begin
        if (mod_more) begin
          scan_q <= scan_q - QW'(n_eff);
        end
      end
      S_SCAN: begin
        if (cur.req_type == REQ_INSERT) begin
          if ((step == 4'd0) || (rd_cnt < best_cnt)) begin
            best     <= scan_q;
            best_cnt <= rd_cnt;
          end
        end else if (rd_cnt != '0) begin
          found    <= 1'b1;
          best     <= scan_q;
          best_cnt <= rd_cnt;
        end
        scan_q <= scan_wrap;
        step   <= step + 4'd1;
      end
      S_ACT: begin
        res.data_out <= 8'd0;
        if (cur.req_type == REQ_INSERT) begin
          if (is_full) begin
            res.status      <= ST_FULL;
            res.queue_index <= 3'd0;
            res.queue_level <= 7'd0;
          end else begin
            res.status      <= ST_INSERTED;
            res.queue_index <= 3'(best);
            res.queue_level <= 7'(best_cnt + CW'(1));
          end
        end else if (found) begin
          res.status      <= ST_DELETED;
          res.queue_index <= 3'(best);
          res.queue_level <= 7'(best_cnt - CW'(1));
        end else begin
          res.status      <= ST_EMPTY;
          res.queue_index <= 3'd0;
          res.queue_level <= 7'd0;
        end
      end
      S_RDWAIT: begin
        res.data_out <= ram_rdata;
      end
      default: begin
      end
    endcase
  end

  // Queue counts, heads and the round-robin pointer.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < QUEUES; i++) begin
        cnt[i]  <= '0;
        head[i] <= '0;
      end
      rr_ptr <= '0;
    end else begin
      if ((state == S_MOD) && !mod_more) begin
        rr_ptr <= scan_wrap;
      end
      if (ram_we) begin
        cnt[best] <= best_cnt + CW'(1);
      end
      if (ram_re) begin
        cnt[best]  <= best_cnt - CW'(1);
        head[best] <= head_inc;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if ((state == S_DONE) && out_free) begin
      rsp_valid <= 1'b1;
    end else if (rsp_valid && !rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_DONE) && out_free) begin
      rsp <= res;
    end
  end

`ifndef SYNTHESIS
  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (int'(scan_q) < QUEUES))
    else $error("scan index beyond the queue array");

  a_rr_in_range: assert property (@(posedge clk) disable iff (rst)
    int'(rr_ptr) < QUEUES)
    else $error("round-robin pointer beyond the queue array");

  a_insert_level: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (rsp.status == ST_INSERTED)) |-> (rsp.queue_level != 7'd0))
    else $error("inserted transaction reports an empty queue");

  a_done_loads: assert property (@(posedge clk) disable iff (rst)
    ((state == S_DONE) && out_free) |=> (rsp_valid && (state == S_IDLE)))
    else $error("finished request did not reach the result register");
`endif

endmodule

FILE: src/sqird_ram.sv
module sqird_ram #(
  parameter int AW = 9
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [1 << AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
